FILE: rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ltfr_pkg.sv
package ltfr_pkg;

    localparam int MAX_FRAME = 64;
    localparam int STORE_AW  = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam int LEN_W     = 7;
    localparam int BYTE_W    = 8;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_BYTE    = 2'd0;
    localparam logic [OP_W-1:0] OP_READ    = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_GOOD      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_TRAIL = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_LEAD  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REFUSED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_READ      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd6;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_BYTE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRAIL_BYTE   = 2'd2;

    localparam logic [LEN_W-1:0]  RST_FRAME_LENGTH = 7'd16;
    localparam logic [BYTE_W-1:0] RST_LEAD_BYTE    = 8'd254;
    localparam logic [BYTE_W-1:0] RST_TRAIL_BYTE   = 8'd255;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] rx_byte;
        logic [BYTE_W-1:0] read_index;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   read_data;
        logic                frame_ready;
    } out_word_t;

    typedef struct packed {
        logic [LEN_W-1:0]  frame_length;
        logic [BYTE_W-1:0] lead_byte;
        logic [BYTE_W-1:0] trail_byte;
    } cfg_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                frame_ready;
        logic                rd_hit;
    } ctrl_result_t;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [BYTE_W-1:0]   data;
    } mem_wr_t;

endpackage

FILE: rtl/lead_trail_frame_receiver_unit.sv
// Fixed-length frame receiver with lead and trail byte check.
// Input words (s_valid/s_ready, s_data) carry one op each: a received byte,
// a read of a stored frame byte by index, or a release of the held frame.
// Every input word gives exactly one result word on m_valid/m_ready, m_data,
// with status, read data and the frame-held flag after that word.
// Config: cfg_wr_en writes cfg_wdata to register cfg_index (0 frame length,
// 1 lead byte, 2 trail byte) at the clock edge; other indexes are ignored.
// Write config only while no word is in flight.
// A result passes through stage 1 and the output register before m_valid.
// Throughput: one word per cycle while s_ready is high. Frame state is updated
// in the accept cycle and the 64-byte frame store read port is registered;
// one more result stage lets a word in while a result waits on m_ready.
// Stalls: when both result stages are full and m_ready is low, s_ready drops.
// Reset (aresetn low, synchronous) restores register defaults, empties the
// pipeline, clears fill count and held flag, and marks every stored byte as
// zero; no clearing pass is needed.
`include "assert_macros.svh"

module lead_trail_frame_receiver_unit
    import ltfr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_word_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_word_t            m_data
);

    cfg_t         cfg;
    ctrl_result_t ctrl_res;
    mem_wr_t      mem_wr;
    logic [BYTE_W-1:0] ram_rdata;

    logic         accept;
    logic         s1_move;
    logic         s1_valid_reg;
    logic         s1_valid_next;
    ctrl_result_t s1_res_reg;
    logic         m_valid_reg;
    logic         m_valid_next;
    out_word_t    m_data_reg;

    assign s1_move = !m_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || s1_move;
    assign accept  = s_valid && s_ready;

    ltfr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ltfr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .accept  (accept),
        .word    (s_data),
        .result  (ctrl_res),
        .mem_wr  (mem_wr)
    );

    ltfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_FRAME)
    ) u_store (
        .clk   (aclk),
        .we    (mem_wr.en),
        .waddr (mem_wr.addr),
        .wdata (mem_wr.data),
        .re    (accept),
        .raddr (STORE_AW'(s_data.read_index)),
        .rdata (ram_rdata)
    );

    assign s1_valid_next = accept || (s1_valid_reg && !s1_move);
    assign m_valid_next  = s1_move ? s1_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_res_reg <= ctrl_res;
        end
        if (s1_move && s1_valid_reg) begin
            m_data_reg.status      <= s1_res_reg.status;
            m_data_reg.read_data   <= s1_res_reg.rd_hit ? ram_rdata : '0;
            m_data_reg.frame_ready <= s1_res_reg.frame_ready;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_IMPLY(a_good_sets_ready, aclk, aresetn,
        m_valid && m_data.status == ST_GOOD, m_data.frame_ready, "good frame not held")
    `ASSERT_IMPLY(a_data_only_on_read, aclk, aresetn,
        m_valid && m_data.read_data != '0, m_data.status == ST_READ, "data on non-read word")
    `ASSERT_NEXT(a_s1_holds_on_stall, aclk, aresetn,
        s1_valid_reg && !s1_move, s1_valid_reg && $stable(s1_res_reg), "stage 1 word lost")

endmodule

FILE: rtl/ltfr_ram.sv
module ltfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ltfr_cfg_regs.sv
module ltfr_cfg_regs
    import ltfr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FRAME_LENGTH: cfg_next.frame_length = cfg_wdata[LEN_W-1:0];
                REG_LEAD_BYTE:    cfg_next.lead_byte    = cfg_wdata;
                REG_TRAIL_BYTE:   cfg_next.trail_byte   = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_length <= RST_FRAME_LENGTH;
            cfg_reg.lead_byte    <= RST_LEAD_BYTE;
            cfg_reg.trail_byte   <= RST_TRAIL_BYTE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/ltfr_ctrl.sv
module ltfr_ctrl
    import ltfr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  cfg_t         cfg,
    input  logic         accept,
    input  in_word_t     word,
    output ctrl_result_t result,
    output mem_wr_t      mem_wr
);

    logic [LEN_W-1:0]     fill_reg;
    logic [LEN_W-1:0]     fill_next;
    logic                 held_reg;
    logic                 held_next;
    logic [MAX_FRAME-1:0] valid_reg;
    logic [MAX_FRAME-1:0] valid_next;

    logic [LEN_W-1:0]    eff_len;
    logic [LEN_W-1:0]    fill_base;
    logic [LEN_W-1:0]    fill_inc;
    logic [STORE_AW-1:0] rd_addr;

    always_comb begin
        if (cfg.frame_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (int'(cfg.frame_length) > MAX_FRAME) begin
            eff_len = LEN_W'(MAX_FRAME);
        end else begin
            eff_len = cfg.frame_length;
        end
    end

    // length may have been lowered mid-frame: restart at the first slot
    assign fill_base = (fill_reg >= eff_len) ? '0 : fill_reg;
    assign fill_inc  = fill_base + LEN_W'(1);
    assign rd_addr   = STORE_AW'(word.read_index);

    always_comb begin
        fill_next      = fill_reg;
        held_next      = held_reg;
        result.status  = ST_REFUSED;
        result.rd_hit  = 1'b0;
        mem_wr.en      = 1'b0;
        mem_wr.addr    = STORE_AW'(fill_base);
        mem_wr.data    = word.rx_byte;
        unique case (word.op)
            OP_BYTE: begin
                if (!held_reg) begin
                    mem_wr.en = accept;
                    if (fill_base == '0 && word.rx_byte != cfg.lead_byte) begin
                        fill_next     = '0;
                        result.status = ST_BAD_LEAD;
                    end else if (fill_inc < eff_len) begin
                        fill_next     = fill_inc;
                        result.status = ST_STORED;
                    end else if (word.rx_byte != cfg.trail_byte) begin
                        fill_next     = '0;
                        result.status = ST_BAD_TRAIL;
                    end else begin
                        fill_next     = fill_inc;
                        held_next     = 1'b1;
                        result.status = ST_GOOD;
                    end
                end
            end
            OP_READ: begin
                result.status = ST_READ;
                // never-written entries read as zero
                result.rd_hit = (word.read_index < {1'b0, eff_len}) && valid_reg[rd_addr];
            end
            OP_RELEASE: begin
                fill_next     = '0;
                held_next     = 1'b0;
                result.status = ST_RELEASED;
            end
            default: begin
                result.status = ST_REFUSED;
            end
        endcase
        result.frame_ready = held_next;
    end

    always_comb begin
        valid_next = valid_reg;
        if (mem_wr.en) begin
            valid_next[mem_wr.addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            held_reg  <= 1'b0;
            valid_reg <= '0;
        end else begin
            if (accept) begin
                fill_reg <= fill_next;
                held_reg <= held_next;
            end
            valid_reg <= valid_next;
        end
    end

endmodule

FILE: bench/frame_result_checker.sv
module frame_result_checker
    import ltfr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_wdata,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  in_word_t             s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  out_word_t            m_data,
    output int                   fail_count,
    output int                   outstanding
);

    logic [BYTE_W-1:0] frame_bytes [MAX_FRAME];
    int unsigned       fill;
    logic              held;
    logic [LEN_W-1:0]  len_cfg;
    logic [BYTE_W-1:0] lead_cfg;
    logic [BYTE_W-1:0] trail_cfg;
    out_word_t         expected_results [$];
    int                fail_tally = 0;

    function automatic int unsigned active_length();
        int unsigned n;
        n = len_cfg;
        if (n == 0) n = 1;
        if (n > MAX_FRAME) n = MAX_FRAME;
        return n;
    endfunction

    function automatic logic [STATUS_W-1:0] accept_byte(logic [BYTE_W-1:0] b);
        int unsigned n;
        n = active_length();
        if (held) return ST_REFUSED;
        // length may have been lowered under a partial frame
        if (fill >= n) fill = 0;
        frame_bytes[fill] = b;
        fill++;
        if (fill == 1 && b != lead_cfg) begin
            fill = 0;
            return ST_BAD_LEAD;
        end
        if (fill < n) return ST_STORED;
        if (frame_bytes[n-1] != trail_cfg) begin
            fill = 0;
            return ST_BAD_TRAIL;
        end
        held = 1'b1;
        return ST_GOOD;
    endfunction

    function automatic out_word_t predict_result(in_word_t w);
        out_word_t r;
        r = '0;
        case (w.op)
            OP_BYTE: r.status = accept_byte(w.rx_byte);
            OP_READ: begin
                r.status = ST_READ;
                if (w.read_index < active_length())
                    r.read_data = frame_bytes[w.read_index[STORE_AW-1:0]];
            end
            OP_RELEASE: begin
                held = 1'b0;
                fill = 0;
                r.status = ST_RELEASED;
            end
            default: r.status = ST_REFUSED;
        endcase
        r.frame_ready = held;
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (got_v !== want_v) begin
            fail_tally++;
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, name, want_v, got_v);
        end
    endtask

    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            for (int i = 0; i < MAX_FRAME; i++) frame_bytes[i] = '0;
            fill = 0;
            held = 1'b0;
            len_cfg = RST_FRAME_LENGTH;
            lead_cfg = RST_LEAD_BYTE;
            trail_cfg = RST_TRAIL_BYTE;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    fail_tally++;
                    $display("%0t: unexpected word, expected none, got %0d/%0d/%0d",
                             $time, m_data.status, m_data.read_data,
                             m_data.frame_ready);
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 8'(want.status), 8'(m_data.status));
                    check_field("read_data", want.read_data, m_data.read_data);
                    check_field("frame_ready", 8'(want.frame_ready),
                                8'(m_data.frame_ready));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FRAME_LENGTH: len_cfg = cfg_wdata[LEN_W-1:0];
                    REG_LEAD_BYTE:    lead_cfg = cfg_wdata;
                    REG_TRAIL_BYTE:   trail_cfg = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_results.push_back(predict_result(s_data));
        end
        fail_count <= fail_tally;
        outstanding <= expected_results.size();
    end

endmodule

FILE: bench/testbench.sv
module testbench;
    import ltfr_pkg::*;

    localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 8;

    typedef enum {FRAME_GOOD, FRAME_BAD_TRAIL, FRAME_BAD_LEAD, FRAME_CUT} frame_kind_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    in_word_t             s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_word_t            m_data;
    int                   fail_count;
    int                   outstanding;

    int          send_idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_req = 1'b0;
    int          items_sent = 0;
    int unsigned cur_len = RST_FRAME_LENGTH;
    logic [7:0]  cur_lead = RST_LEAD_BYTE;
    logic [7:0]  cur_trail = RST_TRAIL_BYTE;

    lead_trail_frame_receiver_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    frame_result_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    task automatic put_word(input logic [OP_W-1:0] op_v, input logic [7:0] rx,
                            input logic [7:0] idx);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{op: op_v, rx_byte: rx, read_index: idx};
        do @(posedge aclk); while (!s_ready);
        if (op_v != OP_UNUSED) items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        put_word(OP_BYTE, b, 8'($urandom_range(255)));
    endtask

    task automatic send_read(input logic [7:0] idx);
        put_word(OP_READ, 8'($urandom_range(255)), idx);
    endtask

    task automatic send_release();
        put_word(OP_RELEASE, 8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    // drop valid and wait until every result is back
    task automatic quiesce();
        @(negedge aclk);
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_FRAME_LENGTH: begin
                cur_len = value[LEN_W-1:0];
                if (cur_len == 0) cur_len = 1;
                if (cur_len > MAX_FRAME) cur_len = MAX_FRAME;
            end
            REG_LEAD_BYTE:  cur_lead = value;
            REG_TRAIL_BYTE: cur_trail = value;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] len, input logic [7:0] lead,
                              input logic [7:0] trail);
        quiesce();
        write_reg(REG_FRAME_LENGTH, len);
        write_reg(REG_LEAD_BYTE, lead);
        write_reg(REG_TRAIL_BYTE, trail);
    endtask

    task automatic send_frame(input frame_kind_t kind);
        int unsigned cut;
        logic [7:0]  b;
        cut = (cur_len > 1) ? $urandom_range(cur_len - 1, 1) : 1;
        for (int unsigned i = 0; i < cur_len; i++) begin
            if (kind == FRAME_CUT && i == cut) break;
            if ($urandom_range(9) == 0) b = $urandom_range(1) ? cur_lead : cur_trail;
            else b = 8'($urandom_range(255));
            if (i == cur_len - 1)
                b = (kind == FRAME_BAD_TRAIL) ? cur_trail ^ 8'($urandom_range(255, 1))
                                              : cur_trail;
            if (i == 0)
                b = (kind == FRAME_BAD_LEAD) ? cur_lead ^ 8'($urandom_range(255, 1))
                                             : cur_lead;
            send_byte(b);
            if (kind == FRAME_BAD_LEAD) break;
        end
        if (kind == FRAME_CUT) send_release();
        if (kind == FRAME_GOOD) begin
            repeat ($urandom_range(4))
                send_read(($urandom_range(3) != 0) ? 8'($urandom_range(cur_len - 1))
                                                   : 8'($urandom_range(255)));
            if ($urandom_range(3) == 0) send_byte(8'($urandom_range(255)));
            send_release();
        end
    endtask

    task automatic random_traffic(input int count);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 55)      send_frame(FRAME_GOOD);
            else if (pick < 65) send_frame(FRAME_BAD_TRAIL);
            else if (pick < 73) send_frame(FRAME_BAD_LEAD);
            else if (pick < 80) send_frame(FRAME_CUT);
            else if (pick < 88) send_read(8'($urandom_range(255)));
            else if (pick < 93) send_byte(8'($urandom_range(255)));
            else if (pick < 96) send_release();
            else put_word(OP_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)));
        end
        // leave a partial frame behind for the next length setting
        send_byte(cur_lead);
        send_byte(8'($urandom_range(255)));
    endtask

    initial begin
        logic [7:0] len_seq   [PHASES];
        logic [7:0] lead_seq  [PHASES];
        logic [7:0] trail_seq [PHASES];
        int         count_seq [PHASES];
        len_seq   = '{8'd5, 8'h83, 8'd1, 8'd0, 8'd64, 8'd127, 8'd2, 8'd16};
        lead_seq  = '{8'h00, 8'hFF, 8'h00, 8'h96, 8'h4B, 8'hFF, 8'hC7, 8'h1E};
        trail_seq = '{8'hFF, 8'h00, 8'hFF, 8'h96, 8'hB4, 8'h00, 8'h3A, 8'hE1};
        // long frames overshoot their phase count by about half a frame
        count_seq = '{75, 75, 75, 75, 40, 40, 75, 70};

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_FRAME_LENGTH;
        cfg_wdata = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part
        set_config(8'd4, 8'hA5, 8'h5A);
        write_reg(REG_UNUSED, 8'h01);
        send_read(8'hFF);
        send_read(8'h00);
        send_release();
        put_word(OP_UNUSED, 8'hFF, 8'hFF);
        send_byte(8'h00);
        send_byte(8'hA5);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h5A);
        send_byte(8'h5A);
        send_read(8'd0);
        send_read(8'd3);
        send_read(8'd4);
        send_release();
        send_byte(8'hA5);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hA5);
        send_byte(8'h01);
        // length drops under the partial frame
        set_config(8'd2, 8'hA5, 8'h01);
        send_byte(8'hA5);
        send_byte(8'h01);
        send_release();
        set_config(8'd0, 8'h3C, 8'h3C);
        send_byte(8'h3C);
        send_release();

        for (int p = 0; p < PHASES; p++) begin
            set_config(len_seq[p], lead_seq[p], trail_seq[p]);
            send_idle_pct = (p % 4 == 1) ? 61 : (p % 4 == 3) ? 8 : 0;
            stall_pct     = (p % 4 == 2) ? 61 : (p % 4 == 3) ? 8 : 0;
            if (p == 0) hold_req = 1'b1;
            random_traffic(count_seq[p]);
        end

        send_idle_pct = 0;
        stall_pct = 0;
        quiesce();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/ltfr_pkg.sv
rtl/ltfr_ram.sv
rtl/ltfr_cfg_regs.sv
rtl/ltfr_ctrl.sv
rtl/lead_trail_frame_receiver_unit.sv
bench/frame_result_checker.sv
bench/testbench.sv
